[sv/dhca_pkg.sv]
`default_nettype none

package dhca_pkg;

  // field and register widths
  localparam int COUNT_W     = 7;
  localparam int LOAD_W      = 8;
  localparam int BYTE_W      = 8;
  localparam int OUT_IDX_W   = 6;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_COUNT    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SERVER_CAPACITY = 4'd1;

  localparam logic [COUNT_W-1:0] SERVER_COUNT_RESET    = 7'd1;
  localparam logic [LOAD_W-1:0]  SERVER_CAPACITY_RESET = 8'd1;

  localparam int MAX_SERVERS_DEFAULT = 64;

  // hash constants; 104729 * 255 + 123 fits in 25 bits
  localparam int DIVIDEND_W = 25;
  localparam int DIV_CNT_W  = 5;
  localparam logic [DIVIDEND_W-1:0] HASH_MUL_START  = 25'd7919;
  localparam logic [DIVIDEND_W-1:0] HASH_MUL_STRIDE = 25'd104729;
  localparam logic [DIVIDEND_W-1:0] HASH_ADD_STRIDE = 25'd123;

  typedef struct packed {
    logic clr_step;
    logic byte_take;
    logic hash_load;
    logic div_step;
    logic probe_init;
    logic chk;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_done;
    logic hit;
    logic probe_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

[sv/dhca_ram.sv]
`default_nettype none

module dhca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[sv/dhca_ctrl.sv]
`default_nettype none

module dhca_ctrl
  import dhca_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic       key_last_i,
  output logic            in_ready_o,
  input  wire dp_status_t status_i,
  output ctrl_cmd_t       cmd_o
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.byte_take = 1'b1;
          if (key_last_i) begin
            cmd_o.hash_load = 1'b1;
            state_d         = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (status_i.div_done) begin
          cmd_o.probe_init = 1'b1;
          state_d          = S_RD;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        if (status_i.hit || status_i.probe_last) begin
          state_d = S_OUT;
        end else begin
          state_d = S_RD;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[sv/dhca_datapath.sv]
`default_nettype none

module dhca_datapath
  import dhca_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire ctrl_cmd_t             cmd_i,
  output dp_status_t                 status_o,
  input  wire logic                  cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [BYTE_W-1:0]     key_byte_i,
  input  wire logic                  key_last_i,
  input  wire logic                  out_ready_i,
  output logic                       out_valid_o,
  output logic                       placed_o,
  output logic [OUT_IDX_W-1:0]       server_index_o,
  output logic                       moved_o,
  output logic [OUT_IDX_W-1:0]       previous_server_o,
  output logic [LOAD_W-1:0]          new_load_o
);

  localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam logic [COUNT_W-1:0] MaxCnt =
    COUNT_W'((MAX_SERVERS > 127) ? 127 : MAX_SERVERS);
  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(MAX_SERVERS - 1);

  // configuration
  logic [COUNT_W-1:0] count_q;
  logic [LOAD_W-1:0]  cap_cfg_q;

  // key folding and hashing
  logic [BYTE_W-1:0]     cs_q;
  logic [BYTE_W-1:0]     cs_next;
  logic [DIVIDEND_W-1:0] div_a_q, div_b_q;
  logic [COUNT_W-1:0]    rem_a_q, rem_b_q;
  logic [DIV_CNT_W-1:0]  bit_cnt_q;
  logic [COUNT_W-1:0]    n_q;
  logic [LOAD_W-1:0]     cap_q;
  logic [COUNT_W-1:0]    cnt_sat, cnt_eff;

  // probe walk
  logic [COUNT_W-1:0] s_q, stride_q, t_q, prev_q;
  logic [COUNT_W:0]   s_sum;
  logic [COUNT_W-1:0] s_adv;
  logic [IDX_W-1:0]   clr_cnt_q;

  // pending result
  logic               res_placed_q, res_moved_q;
  logic [OUT_IDX_W-1:0] res_idx_q, res_prev_q;
  logic [LOAD_W-1:0]  res_load_q;

  logic               out_valid_q;

  // load table
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [LOAD_W-1:0] ram_wdata, ram_rdata;
  logic [LOAD_W-1:0] load_inc;

  function automatic logic [COUNT_W-1:0] rem_step(input logic [COUNT_W-1:0] rem,
                                                  input logic bit_in,
                                                  input logic [COUNT_W-1:0] n);
    logic [COUNT_W:0] tmp;
    logic [COUNT_W:0] diff;
    tmp  = {rem, bit_in};
    diff = tmp - {1'b0, n};
    if (tmp >= {1'b0, n}) begin
      return diff[COUNT_W-1:0];
    end
    return tmp[COUNT_W-1:0];
  endfunction

  assign cs_next = cs_q ^ key_byte_i;
  assign cnt_sat = (count_q > MaxCnt) ? MaxCnt : count_q;
  assign cnt_eff = (cnt_sat == '0) ? COUNT_W'(1) : cnt_sat;

  // next probe, both terms below n
  assign s_sum = {1'b0, s_q} + {1'b0, stride_q};
  always_comb begin
    s_adv = s_sum[COUNT_W-1:0];
    if (s_sum >= {1'b0, n_q}) begin
      s_adv = COUNT_W'(s_sum - {1'b0, n_q});
    end
  end

  assign load_inc  = ram_rdata + LOAD_W'(1);
  assign ram_raddr = IDX_W'(s_q);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = ram_raddr;
    ram_wdata = load_inc;
    if (cmd_i.clr_step) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_q;
      ram_wdata = '0;
    end else if (cmd_i.chk && status_o.hit) begin
      ram_we = 1'b1;
    end
  end

  dhca_ram #(
    .WIDTH (LOAD_W),
    .DEPTH (MAX_SERVERS)
  ) u_load_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign status_o.clr_done   = (clr_cnt_q == LastIdx);
  assign status_o.div_done   = (bit_cnt_q == '0);
  assign status_o.hit        = (ram_rdata < cap_q);
  assign status_o.probe_last = (t_q == n_q - COUNT_W'(1));
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= SERVER_COUNT_RESET;
      cap_cfg_q   <= SERVER_CAPACITY_RESET;
      cs_q        <= '0;
      bit_cnt_q   <= '0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_SERVER_COUNT:    count_q   <= cfg_data_i[COUNT_W-1:0];
          CFG_SERVER_CAPACITY: cap_cfg_q <= cfg_data_i[LOAD_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.byte_take) begin
        cs_q <= key_last_i ? '0 : cs_next;
      end
      if (cmd_i.hash_load) begin
        bit_cnt_q <= DIV_CNT_W'(DIVIDEND_W);
      end else if (cmd_i.div_step) begin
        bit_cnt_q <= bit_cnt_q - DIV_CNT_W'(1);
      end
      if (cmd_i.clr_step) begin
        clr_cnt_q <= clr_cnt_q + IDX_W'(1);
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_load) begin
      div_a_q <= DIVIDEND_W'(cs_next) * HASH_MUL_START;
      div_b_q <= DIVIDEND_W'(cs_next) * HASH_MUL_STRIDE + HASH_ADD_STRIDE;
      rem_a_q <= '0;
      rem_b_q <= '0;
      n_q     <= cnt_eff;
      cap_q   <= cap_cfg_q;
    end
    if (cmd_i.div_step) begin
      rem_a_q <= rem_step(rem_a_q, div_a_q[DIVIDEND_W-1], n_q);
      rem_b_q <= rem_step(rem_b_q, div_b_q[DIVIDEND_W-1], n_q);
      div_a_q <= div_a_q << 1;
      div_b_q <= div_b_q << 1;
    end
    if (cmd_i.probe_init) begin
      s_q      <= rem_a_q;
      stride_q <= (rem_b_q == '0) ? COUNT_W'(1) : rem_b_q;
      t_q      <= '0;
    end
    if (cmd_i.chk) begin
      if (status_o.hit) begin
        res_placed_q <= 1'b1;
        res_idx_q    <= s_q[OUT_IDX_W-1:0];
        res_moved_q  <= (t_q != '0);
        res_prev_q   <= (t_q != '0) ? prev_q[OUT_IDX_W-1:0] : '0;
        res_load_q   <= load_inc;
      end else if (status_o.probe_last) begin
        res_placed_q <= 1'b0;
        res_idx_q    <= '0;
        res_moved_q  <= 1'b0;
        res_prev_q   <= '0;
        res_load_q   <= '0;
      end else begin
        prev_q <= s_q;
        t_q    <= t_q + COUNT_W'(1);
        s_q    <= s_adv;
      end
    end
    if (cmd_i.out_load) begin
      placed_o          <= res_placed_q;
      server_index_o    <= res_idx_q;
      moved_o           <= res_moved_q;
      previous_server_o <= res_prev_q;
      new_load_o        <= res_load_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

[sv/double_hash_capacity_allocator_core.sv]
// Double-hash capacity allocator. Key bytes come in one transfer each and are
// folded into an 8-bit xor checksum; a plain byte is taken and the block is
// ready again at once. The byte marked last starts placement: two remainders
// (start and stride of the probe sequence, modulo the effective server
// count) come out of two bit-serial remainder units that step side by side
// on one bit counter, then servers are probed one by one, each probe passing
// through a read state and a check state, since the load table's read port
// is registered; the walk makes at most as many probes as the effective
// server count. No bytes are taken during that walk. One result transfer
// follows each last byte, held in an output register, so the next key can
// stream in while it waits. After reset a clearing pass zeroes the load
// table, with no input taken; configuration writes are accepted at any time
// but should be issued only while the block is idle.
`default_nettype none

module double_hash_capacity_allocator_core
  import dhca_pkg::*;
#(
  parameter int MAX_SERVERS = MAX_SERVERS_DEFAULT
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // key byte stream
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [BYTE_W-1:0]     key_byte_i,
  input  wire logic                  key_last_i,
  // placement results
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic                       placed_o,
  output logic [OUT_IDX_W-1:0]       server_index_o,
  output logic                       moved_o,
  output logic [OUT_IDX_W-1:0]       previous_server_o,
  output logic [LOAD_W-1:0]          new_load_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // registers are plain flops, every write is accepted
  assign cfg_ready_o = 1'b1;

  // sequencer: clear pass, byte intake, remainder steps, probe walk, result
  dhca_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .key_last_i (key_last_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // checksum, remainder unit, probe registers, load table and output register
  dhca_datapath #(
    .MAX_SERVERS (MAX_SERVERS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .status_o          (status),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .key_byte_i        (key_byte_i),
    .key_last_i        (key_last_i),
    .out_ready_i       (out_ready_i),
    .out_valid_o       (out_valid_o),
    .placed_o          (placed_o),
    .server_index_o    (server_index_o),
    .moved_o           (moved_o),
    .previous_server_o (previous_server_o),
    .new_load_o        (new_load_o)
  );

endmodule

`default_nettype wire

[sv/dhca_checker.sv]
`default_nettype none

module dhca_checker
  import dhca_pkg::*;
(
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_ready_o,
  input wire logic                  key_last_i,
  input wire logic                  out_valid_o,
  input wire logic                  out_ready_i,
  input wire logic                  placed_o,
  input wire logic [OUT_IDX_W-1:0]  server_index_o,
  input wire logic                  moved_o,
  input wire logic [OUT_IDX_W-1:0]  previous_server_o,
  input wire logic [LOAD_W-1:0]     new_load_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(placed_o) &&
      $stable(server_index_o) && $stable(new_load_o) && $stable(moved_o))
    else $error("stalled result changed");

  // a failed placement carries only zeros
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !placed_o |-> server_index_o == '0 && !moved_o &&
      previous_server_o == '0 && new_load_o == '0)
    else $error("unplaced result has nonzero fields");

  // first-probe placement reports no previous server
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && placed_o && !moved_o |-> previous_server_o == '0)
    else $error("previous server set without a move");

  // a placed request leaves a load of at least one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && placed_o |-> new_load_o != '0)
    else $error("placed with zero load");

  // the probe walk blocks byte intake right after a last byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && key_last_i |=> !in_ready_o)
    else $error("byte taken during placement");

endmodule

bind double_hash_capacity_allocator_core dhca_checker u_dhca_checker (.*);

`default_nettype wire
